### rtl/integer_sorter_assert.svh
// integer_sorter_assert.svh: assertion macros for the integer sorter checkers
// no dependencies; included by the checker file
`ifndef INTEGER_SORTER_ASSERT_SVH
`define INTEGER_SORTER_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define ISORT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("isort assertion failed");

// next-cycle implication, disabled while reset is low
`define ISORT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("isort assertion failed");

`endif

### rtl/isort_pkg.sv
// isort_pkg: sizes, types and queue geometry shared by the integer sorter
// no dependencies; compiled before every other file of the block
package isort_pkg;

    localparam int MAX_ITEMS   = 64;
    localparam int CNT_W       = $clog2(MAX_ITEMS + 1);
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QLVL_W      = $clog2(QUEUE_DEPTH + 1);

    typedef logic signed [31:0] t_value;
    typedef logic [CNT_W-1:0]   t_count;

    // one classified item on its way from front to back
    typedef struct packed {
        t_value value;
        logic   is_last;
        logic   keep;
    } t_token;

    // handshake of the token channel between front, queue and back
    typedef struct packed {
        logic   valid;
        t_token token;
    } t_token_chan;

endpackage

### rtl/isort_in_if.sv
// isort_in_if: input channel of the integer sorter (valid, ready, payload)
// depends on isort_pkg
interface isort_in_if;
    logic              valid;
    logic              ready;
    isort_pkg::t_value value;
    logic              is_last;

    modport source (output valid, output value, output is_last, input ready);
    modport sink   (input valid, input value, input is_last, output ready);
endinterface

### rtl/isort_out_if.sv
// isort_out_if: result channel of the integer sorter (valid, ready, payload)
// depends on isort_pkg
interface isort_out_if;
    logic              valid;
    logic              ready;
    isort_pkg::t_value sorted_value;
    logic              last_out;

    modport source (output valid, output sorted_value, output last_out, input ready);
    modport sink   (input valid, input sorted_value, input last_out, output ready);
endinterface

### rtl/isort_front.sv
// isort_front: accepts integers and marks those beyond the block capacity as dropped
// depends on isort_pkg and isort_in_if
module isort_front (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    isort_in_if.sink                 i_in,
    output isort_pkg::t_token_chan   o_tok,
    input  logic                     i_tok_ready
);

    isort_pkg::t_count r_count;
    isort_pkg::t_count n_count;
    logic              w_xfer;
    logic              w_keep;

    assign w_keep = (r_count < isort_pkg::CNT_W'(isort_pkg::MAX_ITEMS));
    assign w_xfer = i_in.valid && i_tok_ready;

    assign i_in.ready           = i_tok_ready;
    assign o_tok.valid          = i_in.valid;
    assign o_tok.token.value    = i_in.value;
    assign o_tok.token.is_last  = i_in.is_last;
    assign o_tok.token.keep     = w_keep;

    // block count restarts after the transfer that closes a block
    always_comb begin
        n_count = r_count;
        if (w_xfer) begin
            if (i_in.is_last) begin
                n_count = '0;
            end else if (w_keep) begin
                n_count = r_count + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

endmodule

### rtl/isort_queue.sv
// isort_queue: short token fifo between front and back
// depends on isort_pkg
module isort_queue (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  isort_pkg::t_token_chan i_push,
    output logic                   o_push_ready,
    output isort_pkg::t_token_chan o_head,
    input  logic                   i_pop_ready
);

    isort_pkg::t_token             r_mem [isort_pkg::QUEUE_DEPTH];
    logic [isort_pkg::QPTR_W-1:0]  r_wr_ptr;
    logic [isort_pkg::QPTR_W-1:0]  r_rd_ptr;
    logic [isort_pkg::QLVL_W-1:0]  r_level;
    logic                          w_push;
    logic                          w_pop;

    assign o_push_ready = (r_level != isort_pkg::QLVL_W'(isort_pkg::QUEUE_DEPTH));
    assign w_push       = i_push.valid && o_push_ready;
    assign o_head.valid = (r_level != '0);
    assign o_head.token = r_mem[r_rd_ptr];
    assign w_pop        = o_head.valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push.token;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_level <= r_level + 1'b1;
            end else if (w_pop && !w_push) begin
                r_level <= r_level - 1'b1;
            end
        end
    end

endmodule

### rtl/isort_back.sv
// isort_back: row of sorting cells; inserts one token a cycle unless draining, then drains in order
// depends on isort_pkg and isort_out_if
module isort_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  isort_pkg::t_token_chan i_head,
    output logic                   o_pop_ready,
    isort_out_if.source            o_out
);

    localparam int N = isort_pkg::MAX_ITEMS;

    isort_pkg::t_value r_cell [N];
    isort_pkg::t_value n_cell [N];
    isort_pkg::t_count r_count;
    isort_pkg::t_count n_count;
    logic              r_draining;
    logic              n_draining;
    logic [N-1:0]      w_go;
    logic              w_pop;
    logic              w_insert;
    logic              w_out_xfer;

    assign o_pop_ready = !r_draining;
    assign w_pop       = i_head.valid && !r_draining;
    assign w_insert    = w_pop && i_head.token.keep;

    assign o_out.valid        = r_draining;
    assign o_out.sorted_value = r_cell[0];
    assign o_out.last_out     = (r_count == isort_pkg::CNT_W'(1));
    assign w_out_xfer         = r_draining && o_out.ready;

    // a cell takes part in the insert shift if it is empty or holds a larger value
    always_comb begin
        for (int i = 0; i < N; i++) begin
            w_go[i] = (isort_pkg::CNT_W'(i) >= r_count) ||
                      (i_head.token.value < r_cell[i]);
        end
    end

    always_comb begin
        n_cell[0] = r_cell[0];
        if (w_insert && w_go[0]) begin
            n_cell[0] = i_head.token.value;
        end else if (w_out_xfer) begin
            n_cell[0] = r_cell[1];
        end
        for (int i = 1; i < N; i++) begin
            n_cell[i] = r_cell[i];
            if (w_insert && w_go[i]) begin
                n_cell[i] = w_go[i-1] ? r_cell[i-1] : i_head.token.value;
            end else if (w_out_xfer && (i < N - 1)) begin
                n_cell[i] = r_cell[(i < N - 1) ? i + 1 : i];
            end
        end
    end

    always_comb begin
        n_count    = r_count;
        n_draining = r_draining;
        if (w_insert) begin
            n_count = r_count + 1'b1;
        end
        if (w_pop && i_head.token.is_last) begin
            n_draining = 1'b1;
        end
        if (w_out_xfer) begin
            n_count = r_count - 1'b1;
            if (o_out.last_out) begin
                n_draining = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < N; i++) begin
            r_cell[i] <= n_cell[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_draining <= 1'b0;
        end else begin
            r_count    <= n_count;
            r_draining <= n_draining;
        end
    end

endmodule

### rtl/integer_sorter.sv
// Integer sorter: takes a block of signed 32-bit integers, one per input transfer, the
// final one flagged by is_last, and returns the block in ascending order, one value per
// result transfer, with last_out on the final one. Up to 64 integers are held; further
// integers of the same block are dropped, and is_last still releases the held ones.
// An input transfer is taken every cycle while the 4-entry queue has room; the back end
// inserts one integer per cycle into a row of 64 compare-and-shift cells. Once the
// closing integer is taken from the queue, the block drains at one result per cycle
// while result ready is high, and no insert happens meanwhile, so the next block's first
// integers wait in the queue; input stalls once the queue is full. With the queue empty,
// the closing integer is written into the queue and, once popped, sets the back end's
// draining register, which raises result valid.
// depends on isort_pkg, isort_in_if, isort_out_if, isort_front, isort_queue, isort_back
module integer_sorter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    isort_in_if.sink    i_in,
    isort_out_if.source o_out
);

    isort_pkg::t_token_chan w_front_tok;
    isort_pkg::t_token_chan w_head;
    logic                   w_push_ready;
    logic                   w_pop_ready;

    isort_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_tok       (w_front_tok),
        .i_tok_ready (w_push_ready)
    );

    isort_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_front_tok),
        .o_push_ready (w_push_ready),
        .o_head       (w_head),
        .i_pop_ready  (w_pop_ready)
    );

    isort_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (w_head),
        .o_pop_ready (w_pop_ready),
        .o_out       (o_out)
    );

endmodule

### rtl/isort_checker.sv
// isort_checker: port-level checks of the integer sorter result stream, bound to the top
// depends on isort_pkg and integer_sorter_assert.svh
`include "integer_sorter_assert.svh"

module isort_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input isort_pkg::t_value i_sorted_value,
    input logic              i_last_out
);

    `ISORT_ASSERT_NEXT(a_valid_holds, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)
    `ISORT_ASSERT_NEXT(a_payload_holds, i_clk, i_rst_n, i_out_valid && !i_out_ready, $stable(i_sorted_value) && $stable(i_last_out))
    // within a block results follow without gaps and never decrease
    `ISORT_ASSERT_NEXT(a_ascending, i_clk, i_rst_n, i_out_valid && i_out_ready && !i_last_out, i_out_valid && (i_sorted_value >= $past(i_sorted_value)))
    // result valid drops after the closing transfer, as the row is then empty
    `ISORT_ASSERT_NEXT(a_gap_after_last, i_clk, i_rst_n, i_out_valid && i_out_ready && i_last_out, !i_out_valid)

endmodule

bind integer_sorter isort_checker u_isort_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_sorted_value (o_out.sorted_value),
    .i_last_out     (o_out.last_out)
);
